/* hw/rtl/rhc_pkg.sv */
// Shared types and defaults for the RGB to HSV/HSL converter.
// No dependencies; imported by every converter module.
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

   localparam int CHANNEL_BITS_DEF  = 8;
   localparam int FRACTION_BITS_DEF = 16;

   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } rhc_sector_type;

   typedef enum logic {
      MODE_HSV = 1'b0,
      MODE_HSL = 1'b1
   } rhc_mode_type;

   typedef struct packed {
      logic valid;
      logic grey;
      logic full;
   } rhc_flags_type;

endpackage

`default_nettype wire

/* hw/rtl/rgb_to_hsv_hsl_converter_unit.sv */
// Top level of the RGB to HSV/HSL converter: mode register, front end, two dividers, output.
// Depends on rhc_pkg, rhc_front and rhc_div.
//
//   channel   ports                                   handshake
//   request   req_red/green/blue/alpha                start, busy
//   response  rsp_hue/saturation/level/alpha_out      rsp_strobe (one cycle, no hold-off)
//   config    csr_write_data                          csr_write_enable
//
// One word per clock in while busy is low, one per clock out, through two front-end
// stages, one divider stage per fraction bit and one output stage. busy is set in reset
// and clears at the first clock edge after it. The pipeline never stalls; the receiver
// must take each strobed word (not enforced). Reset clears the valid bits and the mode.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsv_hsl_converter_unit
   import rhc_pkg::*;
#(
   parameter int CHANNEL_BITS  = CHANNEL_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire  [CHANNEL_BITS-1:0]    req_red,
   input  wire  [CHANNEL_BITS-1:0]    req_green,
   input  wire  [CHANNEL_BITS-1:0]    req_blue,
   input  wire  [CHANNEL_BITS-1:0]    req_alpha,
   output logic                       rsp_strobe,
   output logic [FRACTION_BITS-1:0]   rsp_hue,
   output logic [FRACTION_BITS-1:0]   rsp_saturation,
   output logic [CHANNEL_BITS:0]      rsp_level,
   output logic [CHANNEL_BITS-1:0]    rsp_alpha_out,
   input  wire                        csr_write_enable,
   input  wire                        csr_write_data
);

   localparam int CB = CHANNEL_BITS;
   localparam int FB = FRACTION_BITS;
   localparam int NW = CHANNEL_BITS + 3;

   logic          busy_ff;
   rhc_mode_type  space_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         space_mode_ff <= MODE_HSV;
      end else begin
         busy_ff <= 1'b0;
         if (csr_write_enable) begin
            space_mode_ff <= rhc_mode_type'(csr_write_data);
         end
      end
   end

   assign busy = busy_ff;

   rhc_flags_type  front_flags;
   logic [NW-1:0]  hue_num, hue_den;
   logic [CB-1:0]  sat_num, sat_den;
   logic [CB:0]    front_level;
   logic [CB-1:0]  front_alpha;

   rhc_front #(
      .CHANNEL_BITS (CB)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy_ff),
      .mode      (space_mode_ff),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .alpha     (req_alpha),
      .flags     (front_flags),
      .hue_num   (hue_num),
      .hue_den   (hue_den),
      .sat_num   (sat_num),
      .sat_den   (sat_den),
      .level     (front_level),
      .alpha_out (front_alpha)
   );

   logic [FB-1:0] hue_quot, sat_quot;

   rhc_div #(
      .WIDTH     (NW),
      .QUOT_BITS (FB)
   ) u_hue_div (
      .clock (clock),
      .num   (hue_num),
      .den   (hue_den),
      .quot  (hue_quot)
   );

   rhc_div #(
      .WIDTH     (CB),
      .QUOT_BITS (FB)
   ) u_sat_div (
      .clock (clock),
      .num   (sat_num),
      .den   (sat_den),
      .quot  (sat_quot)
   );

   // carry flags, level and alpha alongside the divider stages
   rhc_flags_type  flags_ff [FB];
   logic [CB:0]    level_ff [FB];
   logic [CB-1:0]  alpha_ff [FB];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FB; i++) begin
            flags_ff[i] <= '0;
         end
      end else begin
         flags_ff[0] <= front_flags;
         for (int i = 1; i < FB; i++) begin
            flags_ff[i] <= flags_ff[i-1];
         end
      end
      level_ff[0] <= front_level;
      alpha_ff[0] <= front_alpha;
      for (int i = 1; i < FB; i++) begin
         level_ff[i] <= level_ff[i-1];
         alpha_ff[i] <= alpha_ff[i-1];
      end
   end

   rhc_flags_type  tail;
   logic [FB-1:0]  hue_in, sat_in;

   always_comb begin
      tail = flags_ff[FB-1];
      if (tail.grey) begin
         hue_in = '0;
         sat_in = '0;
      end else if (tail.full) begin
         hue_in = hue_quot;
         sat_in = {FB{1'b1}};
      end else begin
         hue_in = hue_quot;
         sat_in = sat_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= tail.valid;
      end
      rsp_hue        <= hue_in;
      rsp_saturation <= sat_in;
      rsp_level      <= level_ff[FB-1];
      rsp_alpha_out  <= alpha_ff[FB-1];
   end

endmodule

`default_nettype wire

/* hw/rtl/rhc_front.sv */
// Front end of the converter: max/min, hue sector, hue and saturation operands, level.
// Two register stages. Depends on rhc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhc_front
   import rhc_pkg::*;
#(
   parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   input  wire rhc_mode_type          mode,
   input  wire [CHANNEL_BITS-1:0]     red,
   input  wire [CHANNEL_BITS-1:0]     green,
   input  wire [CHANNEL_BITS-1:0]     blue,
   input  wire [CHANNEL_BITS-1:0]     alpha,
   output rhc_flags_type              flags,
   output logic [CHANNEL_BITS+2:0]    hue_num,
   output logic [CHANNEL_BITS+2:0]    hue_den,
   output logic [CHANNEL_BITS-1:0]    sat_num,
   output logic [CHANNEL_BITS-1:0]    sat_den,
   output logic [CHANNEL_BITS:0]      level,
   output logic [CHANNEL_BITS-1:0]    alpha_out
);

   localparam int CB = CHANNEL_BITS;
   localparam int NW = CHANNEL_BITS + 3;

   // stage A: order the channels
   logic               valid_a_ff;
   rhc_mode_type       mode_a_ff;
   rhc_sector_type     sect_a_ff, sect_a_in;
   logic [CB-1:0]      red_a_ff, green_a_ff, blue_a_ff, alpha_a_ff;
   logic [CB-1:0]      max_a_ff, max_a_in, min_a_ff, min_a_in;

   always_comb begin
      if (red >= green && red >= blue) begin
         sect_a_in = SECT_RED;
         max_a_in  = red;
      end else if (green >= blue) begin
         sect_a_in = SECT_GREEN;
         max_a_in  = green;
      end else begin
         sect_a_in = SECT_BLUE;
         max_a_in  = blue;
      end
      min_a_in = red;
      if (green < min_a_in) begin
         min_a_in = green;
      end
      if (blue < min_a_in) begin
         min_a_in = blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      mode_a_ff  <= mode;
      sect_a_ff  <= sect_a_in;
      red_a_ff   <= red;
      green_a_ff <= green;
      blue_a_ff  <= blue;
      alpha_a_ff <= alpha;
      max_a_ff   <= max_a_in;
      min_a_ff   <= min_a_in;
   end

   // stage B: operands for the two dividers
   logic [CB-1:0]  delta;
   logic [CB:0]    sum;
   logic [CB:0]    full_scale;
   logic [CB:0]    twice_full;
   logic [CB:0]    hsl_high;
   logic [NW-1:0]  d_w, r_w, g_w, b_w, six_d;
   logic [NW-1:0]  hue_num_in;
   logic [CB-1:0]  sat_den_in;
   logic [CB:0]    level_in;
   rhc_flags_type  flags_in;

   always_comb begin
      delta      = max_a_ff - min_a_ff;
      sum        = {1'b0, max_a_ff} + {1'b0, min_a_ff};
      full_scale = {1'b0, {CB{1'b1}}};
      twice_full = {{CB{1'b1}}, 1'b0};
      hsl_high   = twice_full - sum;
      d_w        = NW'(delta);
      r_w        = NW'(red_a_ff);
      g_w        = NW'(green_a_ff);
      b_w        = NW'(blue_a_ff);
      six_d      = (d_w << 2) + (d_w << 1);

      case (sect_a_ff)
         SECT_RED: begin
            if (green_a_ff >= blue_a_ff) begin
               hue_num_in = g_w - b_w;
            end else begin
               hue_num_in = six_d - (b_w - g_w);
            end
         end
         SECT_GREEN: hue_num_in = (d_w << 1) + b_w - r_w;
         SECT_BLUE:  hue_num_in = (d_w << 2) + r_w - g_w;
         default:    hue_num_in = '0;
      endcase

      if (mode_a_ff == MODE_HSL) begin
         level_in = sum;
         if (sum > full_scale) begin
            sat_den_in = hsl_high[CB-1:0];
         end else begin
            sat_den_in = sum[CB-1:0];
         end
      end else begin
         level_in   = {max_a_ff, 1'b0};
         sat_den_in = max_a_ff;
      end

      flags_in.valid = valid_a_ff;
      flags_in.grey  = (delta == '0);
      flags_in.full  = (delta == sat_den_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags <= '0;
      end else begin
         flags <= flags_in;
      end
      hue_num   <= hue_num_in;
      hue_den   <= six_d;
      sat_num   <= delta;
      sat_den   <= sat_den_in;
      level     <= level_in;
      alpha_out <= alpha_a_ff;
   end

endmodule

`default_nettype wire

/* hw/rtl/rhc_div.sv */
// Pipelined restoring divider: fraction bits of num/den for num < den, one bit per stage.
// Depends on rhc_pkg for defaults only.
`timescale 1ns / 1ps
`default_nettype none

module rhc_div
   import rhc_pkg::*;
#(
   parameter int WIDTH     = CHANNEL_BITS_DEF + 3,
   parameter int QUOT_BITS = FRACTION_BITS_DEF
) (
   input  wire                   clock,
   input  wire  [WIDTH-1:0]      num,
   input  wire  [WIDTH-1:0]      den,
   output logic [QUOT_BITS-1:0]  quot
);

   logic [WIDTH-1:0]     rem_ff [QUOT_BITS-1];
   logic [WIDTH-1:0]     den_ff [QUOT_BITS-1];
   logic [QUOT_BITS-1:0] q_ff   [QUOT_BITS];

   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
      logic [WIDTH-1:0]     rem_src, den_src;
      logic [QUOT_BITS-1:0] q_src;
      logic [WIDTH:0]       dbl, diff;
      logic                 take;
      logic [WIDTH-1:0]     rem_in;

      if (k == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign q_src   = q_ff[k-1];
      end

      assign dbl    = {rem_src, 1'b0};
      assign diff   = dbl - {1'b0, den_src};
      assign take   = (dbl >= {1'b0, den_src});
      assign rem_in = take ? diff[WIDTH-1:0] : dbl[WIDTH-1:0];

      always_ff @(posedge clock) begin
         q_ff[k] <= {q_src[QUOT_BITS-2:0], take};
      end

      if (k < QUOT_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_src;
         end
      end
   end

   assign quot = q_ff[QUOT_BITS-1];

endmodule

`default_nettype wire
